// ===== src/ebalu_pkg.sv =====
// shared types and operation codes for the eight-bit alu with flags
`default_nettype none

package ebalu_pkg;

    localparam int unsigned OP_W   = 5;
    localparam int unsigned DATA_W = 8;

    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 5'd0,
        OP_ADC  = 5'd1,
        OP_SUB  = 5'd2,
        OP_SBC  = 5'd3,
        OP_AND  = 5'd4,
        OP_XOR  = 5'd5,
        OP_OR   = 5'd6,
        OP_CP   = 5'd7,
        OP_INC  = 5'd8,
        OP_DEC  = 5'd9,
        OP_RLCA = 5'd10,
        OP_RLA  = 5'd11,
        OP_RRCA = 5'd12,
        OP_RRA  = 5'd13,
        OP_CPL  = 5'd14,
        OP_SCF  = 5'd15,
        OP_CCF  = 5'd16
    } alu_op_t;

    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } flags_t;

endpackage

`default_nettype wire

// ===== src/ebalu_core.sv =====
// combinational datapath: adder, logic unit, rotates and flag rules
`default_nettype none

module ebalu_core (
    input  wire logic [ebalu_pkg::OP_W-1:0]   op,
    input  wire logic [ebalu_pkg::DATA_W-1:0] a,
    input  wire logic [ebalu_pkg::DATA_W-1:0] b,
    input  wire ebalu_pkg::flags_t            flags_in,
    output      logic [ebalu_pkg::DATA_W-1:0] result,
    output      ebalu_pkg::flags_t            flags_out
);
    import ebalu_pkg::*;

    logic                cin;
    logic                use_cin;
    logic [DATA_W:0]     sum;
    logic [4:0]          sum_lo;
    logic [DATA_W:0]     diff;
    logic [4:0]          diff_lo;
    logic [DATA_W-1:0]   inc_val;
    logic [DATA_W-1:0]   dec_val;

    assign use_cin = (op == OP_ADC) || (op == OP_SBC);
    assign cin     = use_cin & flags_in.c;

    assign sum     = {1'b0, a} + {1'b0, b} + {{DATA_W{1'b0}}, cin};
    assign sum_lo  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
    assign diff    = {1'b0, a} - {1'b0, b} - {{DATA_W{1'b0}}, cin};
    assign diff_lo = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};
    assign inc_val = a + 8'd1;
    assign dec_val = a - 8'd1;

    always_comb
    begin
        result    = a;
        flags_out = flags_in;
        case (op)
            OP_ADD, OP_ADC:
            begin
                result      = sum[DATA_W-1:0];
                flags_out.z = (sum[DATA_W-1:0] == '0);
                flags_out.n = 1'b0;
                flags_out.h = sum_lo[4];
                flags_out.c = sum[DATA_W];
            end
            OP_SUB, OP_SBC, OP_CP:
            begin
                if (op != OP_CP)
                begin
                    result = diff[DATA_W-1:0];
                end
                flags_out.z = (diff[DATA_W-1:0] == '0);
                flags_out.n = 1'b1;
                flags_out.h = diff_lo[4];
                flags_out.c = diff[DATA_W];
            end
            OP_AND:
            begin
                result    = a & b;
                flags_out = '{z: ((a & b) == '0), n: 1'b0, h: 1'b1, c: 1'b0};
            end
            OP_XOR:
            begin
                result    = a ^ b;
                flags_out = '{z: ((a ^ b) == '0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            OP_OR:
            begin
                result    = a | b;
                flags_out = '{z: ((a | b) == '0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            OP_INC:
            begin
                result      = inc_val;
                flags_out.z = (inc_val == '0);
                flags_out.n = 1'b0;
                flags_out.h = (a[3:0] == 4'hF);
            end
            OP_DEC:
            begin
                result      = dec_val;
                flags_out.z = (dec_val == '0);
                flags_out.n = 1'b1;
                flags_out.h = (a[3:0] == 4'h0);
            end
            OP_RLCA:
            begin
                result    = {a[DATA_W-2:0], a[DATA_W-1]};
                flags_out = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[DATA_W-1]};
            end
            OP_RLA:
            begin
                result    = {a[DATA_W-2:0], flags_in.c};
                flags_out = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[DATA_W-1]};
            end
            OP_RRCA:
            begin
                result    = {a[0], a[DATA_W-1:1]};
                flags_out = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
            end
            OP_RRA:
            begin
                result    = {flags_in.c, a[DATA_W-1:1]};
                flags_out = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
            end
            OP_CPL:
            begin
                result      = ~a;
                flags_out.n = 1'b1;
                flags_out.h = 1'b1;
            end
            OP_SCF:
            begin
                flags_out.n = 1'b0;
                flags_out.h = 1'b0;
                flags_out.c = 1'b1;
            end
            OP_CCF:
            begin
                flags_out.n = 1'b0;
                flags_out.h = 1'b0;
                flags_out.c = ~flags_in.c;
            end
            default:
            begin
                result    = a;
                flags_out = flags_in;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/eight_bit_alu_with_flags.sv =====
// top level: input register, alu datapath and result register with handshakes
//
// Eight-bit accumulator ALU with Z/N/H/C flags. Each transaction carries an
// operation code, the accumulator, an operand and the incoming flags, and
// produces one result transaction with the new value and flags. The block is
// a two-register pipe: a transaction is captured in the input register, passes
// the adder and flag logic, and lands in the result register when that register
// is empty or being read, and is offered from there. One transaction is
// accepted every cycle while the result side keeps taking; req_ready falls only
// when both registers hold data and rsp_ready is low. Unused operation codes
// pass the accumulator and flags through unchanged.
`default_nettype none

module eight_bit_alu_with_flags (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         req_valid,
    output      logic                         req_ready,
    input  wire logic [ebalu_pkg::OP_W-1:0]   req_type,
    input  wire logic [ebalu_pkg::DATA_W-1:0] acc_in,
    input  wire logic [ebalu_pkg::DATA_W-1:0] operand_in,
    input  wire logic                         zero_in,
    input  wire logic                         subtract_in,
    input  wire logic                         half_in,
    input  wire logic                         carry_in,
    output      logic                         rsp_valid,
    input  wire logic                         rsp_ready,
    output      logic [ebalu_pkg::DATA_W-1:0] result_out,
    output      logic                         zero_out,
    output      logic                         subtract_out,
    output      logic                         half_out,
    output      logic                         carry_out
);
    import ebalu_pkg::*;

    logic                stg_valid_reg;
    logic [OP_W-1:0]     op_reg;
    logic [DATA_W-1:0]   a_reg;
    logic [DATA_W-1:0]   b_reg;
    flags_t              flags_reg;

    logic                res_valid_reg;
    logic [DATA_W-1:0]   res_reg;
    flags_t              res_flags_reg;

    logic                res_load;
    logic                stg_load;
    logic [DATA_W-1:0]   res_next;
    flags_t              res_flags_next;

    assign res_load  = stg_valid_reg && (!res_valid_reg || rsp_ready);
    assign req_ready = !stg_valid_reg || res_load;
    assign stg_load  = req_valid && req_ready;

    ebalu_core u_core (
        .op        (op_reg),
        .a         (a_reg),
        .b         (b_reg),
        .flags_in  (flags_reg),
        .result    (res_next),
        .flags_out (res_flags_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                stg_valid_reg <= req_valid;
            end
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_load)
        begin
            op_reg    <= req_type;
            a_reg     <= acc_in;
            b_reg     <= operand_in;
            flags_reg <= '{z: zero_in, n: subtract_in, h: half_in, c: carry_in};
        end
        if (res_load)
        begin
            res_reg       <= res_next;
            res_flags_reg <= res_flags_next;
        end
    end

    assign rsp_valid    = res_valid_reg;
    assign result_out   = res_reg;
    assign zero_out     = res_flags_reg.z;
    assign subtract_out = res_flags_reg.n;
    assign half_out     = res_flags_reg.h;
    assign carry_out    = res_flags_reg.c;

    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> stg_valid_reg)
        else $error("accepted transaction not held in input register");

    a_full_pipe_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        stg_valid_reg && rsp_valid && !rsp_ready |-> !req_ready)
        else $error("input taken while both registers are full and stalled");

    a_stage_drains: assert property (@(posedge clk) disable iff (!rst_n)
        stg_valid_reg && (!rsp_valid || rsp_ready) |=> rsp_valid)
        else $error("result register missed a ready transaction");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

endmodule

`default_nettype wire
